// ===== sv/ppfl_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfl_pkg
// Shared types and constants of the pixel packet frame latch.
// ----------------------------------------------------------------------------
package ppfl_pkg;

    // packet layout
    localparam logic [7:0] HDR_BYTES  = 8'd5;
    localparam logic [7:0] PIXEL_TYPE = 8'h01;
    localparam int         MAX_PACKET = 250;

    // header byte positions
    localparam logic [7:0] HP_TYPE     = 8'd0;
    localparam logic [7:0] HP_MASK_LO  = 8'd1;
    localparam logic [7:0] HP_MASK_HI  = 8'd2;
    localparam logic [7:0] HP_FRAMES   = 8'd3;

    // commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // header verdicts and packet status codes
    localparam logic [1:0] V_GOOD    = 2'd0;
    localparam logic [1:0] V_GROUP   = 2'd2;
    localparam logic [1:0] V_BAD     = 2'd3;
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;

    // colour channel within a pixel
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // configuration port
    localparam int         CFG_IDX_W  = 8;
    localparam int         CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_GROUP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 8'd1;

    localparam logic [3:0] DEVICE_GROUP_RST = 4'd3;
    localparam logic [5:0] STRIP_LENGTH_RST = 6'd20;

    // result fields carried through the read stage
    typedef struct packed {
        logic        hit;
        logic [5:0]  frame_pixels;
        logic [31:0] frame_version;
        logic [1:0]  packet_status;
    } t_s1_meta;

endpackage

// ===== sv/ppfl_if.sv =====
// ----------------------------------------------------------------------------
// ppfl_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface ppfl_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic       first_byte;
    logic [7:0] packet_length;
    logic [4:0] read_index;

    modport source (output valid, command, rx_byte, first_byte, packet_length, read_index,
                    input ready);
    modport sink   (input valid, command, rx_byte, first_byte, packet_length, read_index,
                    output ready);
endinterface

interface ppfl_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [5:0]  frame_pixels;
    logic [31:0] frame_version;
    logic [1:0]  packet_status;

    modport source (output valid, red, green, blue, frame_pixels, frame_version,
                    packet_status, input ready);
    modport sink   (input valid, red, green, blue, frame_pixels, frame_version,
                    packet_status, output ready);
endinterface

interface ppfl_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ppfl_ram.sv =====
// ----------------------------------------------------------------------------
// ppfl_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/pixel_packet_frame_latch.sv =====
// ----------------------------------------------------------------------------
// pixel_packet_frame_latch
// Byte-serial pixel packet receiver with a double-buffered frame latch.
// ----------------------------------------------------------------------------
// path: pixel ram read in the read stage, then the output register
// throughput: one item per cycle unless the output stalls; header, pixel write and swap
//   all settle at the input transfer, and the pixel ram takes one write and one read each cycle
// reset: synchronous active low; clears control state, the frame counts, the version
//   and the per-entry valid bits of the pixel ram, so no clearing pass is needed
module pixel_packet_frame_latch
    import ppfl_pkg::*;
#(
    parameter int MAX_PIXELS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ppfl_in_if.sink    i_pkt,
    ppfl_cfg_if.sink   i_cfg,
    ppfl_out_if.source o_res
);
    localparam int DEPTH = 2 * MAX_PIXELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_PIXELS + 1);

    // configuration
    logic [3:0] r_device_group;
    logic [5:0] r_strip_length;

    // packet and frame state
    logic [PW-1:0] r_bufpix [2];
    logic [PW-1:0] n_bufpix [2];
    logic          r_active,  n_active;
    logic [31:0]   r_version, n_version;
    logic [7:0]    r_pos,     n_pos;
    logic [7:0]    r_len,     n_len;
    logic [7:0]    r_glow,    n_glow;
    logic [7:0]    r_src,     n_src;
    logic [7:0]    r_frames,  n_frames;
    logic [1:0]    r_verdict, n_verdict;
    logic [1:0]    r_chan,    n_chan;
    logic [7:0]    r_pix,     n_pix;
    logic [15:0]   r_partial, n_partial;
    logic [DEPTH-1:0] r_valid;

    // pipeline
    logic       r_s1_valid;
    t_s1_meta   r_s1, n_s1;
    logic       r_o_valid;
    logic [7:0] r_o_red, r_o_green, r_o_blue;
    logic [5:0] r_o_pixels;
    logic [31:0] r_o_version;
    logic [1:0] r_o_status;

    logic          in_acc, o_load, s1_free;
    logic          w_we, rd_re;
    logic [AW-1:0] w_addr, rd_addr;
    logic [23:0]   w_data, rd_data;

    // effective values with the start of a packet applied
    logic [7:0]  e_pos, e_len, e_glow, e_src, e_frames, e_pix;
    logic [1:0]  e_verdict, e_chan;
    logic [15:0] e_partial;
    logic [7:0]  kept;
    logic [9:0]  stride;
    logic [17:0] prod;
    logic [15:0] mask;
    logic        w_half;
    logic [8:0]  pos_inc;

    assign o_load  = r_s1_valid && (!r_o_valid || o_res.ready);
    assign s1_free = !r_s1_valid || o_load;
    assign i_pkt.ready = s1_free;
    assign in_acc  = i_pkt.valid && s1_free;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_pkt.first_byte) begin
            e_pos     = '0;
            e_len     = i_pkt.packet_length;
            e_verdict = V_GOOD;
            e_chan    = CH_RED;
            e_pix     = '0;
            e_partial = '0;
            e_frames  = '0;
            e_src     = '0;
            e_glow    = '0;
        end else begin
            e_pos     = r_pos;
            e_len     = r_len;
            e_verdict = r_verdict;
            e_chan    = r_chan;
            e_pix     = r_pix;
            e_partial = r_partial;
            e_frames  = r_frames;
            e_src     = r_src;
            e_glow    = r_glow;
        end

        kept = e_src;
        if (kept > 8'(r_strip_length)) kept = 8'(r_strip_length);
        if (kept > 8'(MAX_PIXELS))     kept = 8'(MAX_PIXELS);

        stride  = {1'b0, i_pkt.rx_byte, 1'b0} + 10'(i_pkt.rx_byte);
        prod    = 18'(e_frames) * 18'(stride);
        mask    = {i_pkt.rx_byte, e_glow};
        w_half  = !r_active;
        pos_inc = 9'(e_pos) + 9'd1;

        n_bufpix  = r_bufpix;
        n_active  = r_active;
        n_version = r_version;
        n_pos     = r_pos;
        n_len     = r_len;
        n_glow    = r_glow;
        n_src     = r_src;
        n_frames  = r_frames;
        n_verdict = r_verdict;
        n_chan    = r_chan;
        n_pix     = r_pix;
        n_partial = r_partial;

        w_we    = 1'b0;
        w_addr  = w_half ? AW'(MAX_PIXELS) + AW'(e_pix) : AW'(e_pix);
        w_data  = {i_pkt.rx_byte, e_partial};
        rd_re   = 1'b0;
        rd_addr = r_active ? AW'(MAX_PIXELS) + AW'(i_pkt.read_index)
                           : AW'(i_pkt.read_index);
        n_s1.hit           = 1'b0;
        n_s1.packet_status = ST_NONE;

        if (in_acc) begin
            if (i_pkt.command == CMD_READ) begin
                rd_re    = 1'b1;
                n_s1.hit = (8'(i_pkt.read_index) < 8'(r_bufpix[r_active]))
                        && (8'(i_pkt.read_index) < 8'(MAX_PIXELS))
                        && r_valid[rd_addr];
            end else if (i_pkt.first_byte || (r_pos < r_len)) begin
                n_pos     = e_pos;
                n_len     = e_len;
                n_glow    = e_glow;
                n_src     = e_src;
                n_frames  = e_frames;
                n_verdict = e_verdict;
                n_chan    = e_chan;
                n_pix     = e_pix;
                n_partial = e_partial;

                if (e_pos < HDR_BYTES) begin
                    priority case (e_pos)
                        HP_TYPE: begin
                            if (e_len < HDR_BYTES || i_pkt.rx_byte != PIXEL_TYPE) begin
                                n_verdict = V_BAD;
                            end
                        end
                        HP_MASK_LO: n_glow = i_pkt.rx_byte;
                        HP_MASK_HI: begin
                            if (e_verdict == V_GOOD && !mask[r_device_group]) begin
                                n_verdict = V_GROUP;
                            end
                        end
                        HP_FRAMES: n_frames = i_pkt.rx_byte;
                        default: begin
                            // pixels per frame, then the size checks
                            n_src = i_pkt.rx_byte;
                            if (e_verdict == V_GOOD &&
                                (i_pkt.rx_byte == 8'd0 || e_frames == 8'd0 ||
                                 prod > 18'(MAX_PACKET - 5) ||
                                 19'(e_len) < 19'(HDR_BYTES) + 19'(prod))) begin
                                n_verdict = V_BAD;
                            end
                        end
                    endcase
                end else if (e_verdict == V_GOOD && e_frames != 8'd0 && e_src != 8'd0) begin
                    unique case (e_chan)
                        CH_RED:   n_partial[7:0]  = i_pkt.rx_byte;
                        CH_GREEN: n_partial[15:8] = i_pkt.rx_byte;
                        default:  w_we = (e_pix < kept);
                    endcase
                    if (e_chan == CH_BLUE) begin
                        n_chan = CH_RED;
                        if (9'(e_pix) + 9'd1 == 9'(e_src)) begin
                            // frame complete: publish the inactive half
                            n_pix              = '0;
                            n_bufpix[w_half]   = PW'(kept);
                            n_active           = w_half;
                            n_version          = r_version + 32'd1;
                            n_frames           = e_frames - 8'd1;
                        end else begin
                            n_pix = e_pix + 8'd1;
                        end
                    end else begin
                        n_chan = e_chan + 2'd1;
                    end
                end

                if (pos_inc >= 9'(e_len)) begin
                    n_s1.packet_status = (n_verdict == V_GOOD) ? ST_ACCEPT : n_verdict;
                end
                n_pos = (pos_inc < 9'(e_len)) ? pos_inc[7:0] : e_len;
            end
        end

        n_s1.frame_pixels  = 6'(n_bufpix[n_active]);
        n_s1.frame_version = n_version;
    end

    ppfl_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_re    (rd_re),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_group <= DEVICE_GROUP_RST;
            r_strip_length <= STRIP_LENGTH_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            priority case (i_cfg.index)
                REG_DEVICE_GROUP: r_device_group <= i_cfg.data[3:0];
                REG_STRIP_LENGTH: r_strip_length <= i_cfg.data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bufpix[0] <= '0;
            r_bufpix[1] <= '0;
            r_active    <= 1'b0;
            r_version   <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_glow      <= '0;
            r_src       <= '0;
            r_frames    <= '0;
            r_verdict   <= V_GOOD;
            r_chan      <= CH_RED;
            r_pix       <= '0;
            r_partial   <= '0;
            r_valid     <= '0;
        end else begin
            r_bufpix  <= n_bufpix;
            r_active  <= n_active;
            r_version <= n_version;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_glow    <= n_glow;
            r_src     <= n_src;
            r_frames  <= n_frames;
            r_verdict <= n_verdict;
            r_chan    <= n_chan;
            r_pix     <= n_pix;
            r_partial <= n_partial;
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    // read stage, then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_pkt.valid;
            end
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (o_load) begin
            r_o_red     <= r_s1.hit ? rd_data[7:0]   : 8'd0;
            r_o_green   <= r_s1.hit ? rd_data[15:8]  : 8'd0;
            r_o_blue    <= r_s1.hit ? rd_data[23:16] : 8'd0;
            r_o_pixels  <= r_s1.frame_pixels;
            r_o_version <= r_s1.frame_version;
            r_o_status  <= r_s1.packet_status;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.red           = r_o_red;
    assign o_res.green         = r_o_green;
    assign o_res.blue          = r_o_blue;
    assign o_res.frame_pixels  = r_o_pixels;
    assign o_res.frame_version = r_o_version;
    assign o_res.packet_status = r_o_status;

    // pixel writes only ever land in the inactive half
    a_write_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_active ? (w_addr < AW'(MAX_PIXELS)) : (w_addr >= AW'(MAX_PIXELS))))
        else $error("pixel write into active half");

    // the version moves by one frame at a time
    a_version_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_version != $past(r_version)) |-> (r_version == $past(r_version) + 32'd1))
        else $error("version jumped");

    // a held read stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !o_load) |=> (r_s1_valid && $stable(r_s1)))
        else $error("read stage lost its item");

    // packet bytes never return colour data
    a_status_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.packet_status != ST_NONE) |->
            (o_res.red == 8'd0 && o_res.green == 8'd0 && o_res.blue == 8'd0))
        else $error("colour on a packet byte result");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel packet frame latch. A mirror of the frame
// latch predicts every result from the accepted input transfers; packets are
// mostly well formed with random content, mixed with reads, malformed headers,
// truncated packets and stray bytes, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import ppfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIXELS = 32;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       first_byte;
        logic [7:0] packet_length;
        logic [4:0] read_index;
    } pkt_item_t;

    localparam int ITEM_W = $bits(pkt_item_t);

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [5:0]  frame_pixels;
        logic [31:0] frame_version;
        logic [1:0]  packet_status;
    } readout_t;

    // mirror of the receiver state and double buffer
    class frame_latch_mirror;
        logic [23:0] pixel_store [2*MAX_PIXELS];
        logic [5:0]  half_pixels [2];
        logic        shown_half;
        logic [31:0] version;
        int          byte_pos;
        int          pkt_len;
        logic [7:0]  mask_low;
        int          src_pixels;
        int          frames_left;
        int          frame_offset;
        logic [1:0]  verdict;
        logic [15:0] partial;
        logic [3:0]  dev_group;
        logic [5:0]  strip_len;
        readout_t    due_readouts [$];
        int          errors;

        function new();
            foreach (pixel_store[k]) pixel_store[k] = '0;
            half_pixels[0] = '0;
            half_pixels[1] = '0;
            shown_half     = 1'b0;
            version        = '0;
            byte_pos       = 0;
            pkt_len        = 0;
            mask_low       = '0;
            src_pixels     = 0;
            frames_left    = 0;
            frame_offset   = 0;
            verdict        = V_GOOD;
            partial        = '0;
            dev_group      = DEVICE_GROUP_RST;
            strip_len      = STRIP_LENGTH_RST;
            errors         = 0;
        endfunction

        function void set_register(logic [7:0] idx, logic [7:0] value);
            if (idx == REG_DEVICE_GROUP) dev_group = value[3:0];
            else if (idx == REG_STRIP_LENGTH) strip_len = value[5:0];
        endfunction

        function int kept_pixels();
            int n;
            n = src_pixels;
            if (n > strip_len) n = strip_len;
            if (n > MAX_PIXELS) n = MAX_PIXELS;
            return n;
        endfunction

        function void take_header(logic [7:0] b);
            logic [15:0] mask;
            int          stride;
            if (byte_pos == HP_TYPE) begin
                if (pkt_len < HDR_BYTES || b != PIXEL_TYPE) verdict = V_BAD;
            end else if (byte_pos == HP_MASK_LO) begin
                mask_low = b;
            end else if (byte_pos == HP_MASK_HI) begin
                mask = {b, mask_low};
                if (verdict == V_GOOD && !mask[dev_group]) verdict = V_GROUP;
            end else if (byte_pos == HP_FRAMES) begin
                frames_left = b;
            end else begin
                src_pixels = b;
                if (verdict == V_GOOD) begin
                    stride = 3 * b;
                    if (b == 0 || frames_left == 0 ||
                        frames_left * stride > MAX_PACKET - HDR_BYTES ||
                        pkt_len < HDR_BYTES + frames_left * stride)
                        verdict = V_BAD;
                end
            end
        endfunction

        function void take_data(logic [7:0] b);
            int   stride;
            int   ch;
            int   pix;
            logic w;
            stride = 3 * src_pixels;
            if (verdict != V_GOOD || frames_left == 0 || stride == 0) return;
            ch  = frame_offset % 3;
            pix = frame_offset / 3;
            w   = ~shown_half;
            if (ch == CH_RED) partial[7:0] = b;
            else if (ch == CH_GREEN) partial[15:8] = b;
            else if (pix < kept_pixels()) pixel_store[w * MAX_PIXELS + pix] = {b, partial};
            frame_offset++;
            // frame complete: publish the back half
            if (frame_offset >= stride) begin
                frame_offset   = 0;
                half_pixels[w] = 6'(kept_pixels());
                shown_half     = w;
                version        = version + 32'd1;
                frames_left--;
            end
        endfunction

        function void note_transfer(pkt_item_t it);
            readout_t r;
            logic     take;
            r = '0;
            if (it.command == CMD_READ) begin
                if (it.read_index < half_pixels[shown_half] && it.read_index < MAX_PIXELS)
                    {r.blue, r.green, r.red} =
                        pixel_store[shown_half * MAX_PIXELS + it.read_index];
            end else begin
                take = 1'b1;
                if (it.first_byte) begin
                    byte_pos     = 0;
                    pkt_len      = it.packet_length;
                    verdict      = V_GOOD;
                    frame_offset = 0;
                    partial      = '0;
                    frames_left  = 0;
                    src_pixels   = 0;
                    mask_low     = '0;
                end else if (byte_pos >= pkt_len) begin
                    take = 1'b0;
                end
                if (take) begin
                    if (byte_pos < HDR_BYTES) take_header(it.rx_byte);
                    else take_data(it.rx_byte);
                    if (byte_pos + 1 >= pkt_len)
                        r.packet_status = (verdict == V_GOOD) ? ST_ACCEPT : verdict;
                    byte_pos++;
                    if (byte_pos >= pkt_len) byte_pos = pkt_len;
                end
            end
            r.frame_pixels  = half_pixels[shown_half];
            r.frame_version = version;
            due_readouts.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_readout(readout_t got);
            readout_t want;
            if (due_readouts.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_readouts.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("frame_pixels", want.frame_pixels, got.frame_pixels);
            compare_field("frame_version", want.frame_version, got.frame_version);
            compare_field("packet_status", want.packet_status, got.packet_status);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_receiver = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   items_sent = 0;

    frame_latch_mirror mirror = new();

    ppfl_in_if  pkt_if ();
    ppfl_out_if res_if ();
    ppfl_cfg_if cfg_if ();

    pixel_packet_frame_latch #(
        .MAX_PIXELS(MAX_PIXELS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pkt  (pkt_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each transfer, then pick next ready
    always @(posedge i_clk) begin
        readout_t got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.red           = res_if.red;
            got.green         = res_if.green;
            got.blue          = res_if.blue;
            got.frame_pixels  = res_if.frame_pixels;
            got.frame_version = res_if.frame_version;
            got.packet_status = res_if.packet_status;
            mirror.check_readout(got);
        end
        res_if.ready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic hold_off(input int cycles);
        hold_receiver <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_receiver <= 1'b0;
    endtask

    task automatic push_item(input pkt_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid         <= 1'b1;
        pkt_if.command       <= it.command;
        pkt_if.rx_byte       <= it.rx_byte;
        pkt_if.first_byte    <= it.first_byte;
        pkt_if.packet_length <= it.packet_length;
        pkt_if.read_index    <= it.read_index;
        do @(posedge i_clk); while (!pkt_if.ready);
        mirror.note_transfer(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [7:0] len);
        pkt_item_t it;
        it.command       = CMD_BYTE;
        it.rx_byte       = b;
        it.first_byte    = first;
        it.packet_length = len;
        it.read_index    = 5'($urandom_range(31));
        push_item(it);
    endtask

    task automatic send_read(input logic [4:0] idx);
        pkt_item_t it;
        it.command       = CMD_READ;
        it.rx_byte       = 8'($urandom_range(255));
        it.first_byte    = 1'($urandom_range(1));
        it.packet_length = 8'($urandom_range(255));
        it.read_index    = idx;
        push_item(it);
    endtask

    task automatic send_noise();
        pkt_item_t it;
        it = ITEM_W'($urandom);
        push_item(it);
    endtask

    // header from arguments, then random frame data; reads mixed in
    task automatic send_packet(input logic [7:0] len, input logic [7:0] ptype,
                               input logic [15:0] mask, input logic [7:0] frames,
                               input logic [7:0] ppf, input int n_bytes, input int read_pct);
        logic [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            if (i == HP_TYPE) b = ptype;
            else if (i == HP_MASK_LO) b = mask[7:0];
            else if (i == HP_MASK_HI) b = mask[15:8];
            else if (i == HP_FRAMES) b = frames;
            else if (i == HDR_BYTES - 1) b = ppf;
            else b = 8'($urandom_range(255));
            if ($urandom_range(99) < read_pct) send_read(5'($urandom_range(31)));
            send_byte(b, i == 0, (i == 0) ? len : 8'($urandom_range(255)));
        end
    endtask

    task automatic random_packet();
        int          ppf;
        int          frames;
        int          frame_room;
        int          need;
        int          len;
        int          n_bytes;
        int          spare;
        logic [7:0]  ptype;
        logic [15:0] mask;
        ppf        = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(1, 81);
        frame_room = (MAX_PACKET - HDR_BYTES) / (3 * ppf);
        frames     = $urandom_range(1, (frame_room < 6) ? frame_room : 6);
        ptype      = PIXEL_TYPE;
        mask       = 16'($urandom_range(16'hFFFF)) | (16'd1 << mirror.dev_group);
        need       = HDR_BYTES + frames * 3 * ppf;
        len        = need;
        spare      = 255 - need;
        if ($urandom_range(9) == 0) len = need + $urandom_range(0, (spare < 6) ? spare : 6);
        n_bytes    = len + (($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(99) >= 70) begin
            case ($urandom_range(7))
                0: mask = mask & ~(16'd1 << mirror.dev_group);
                1: begin
                    ptype = 8'($urandom_range(255));
                    if (ptype == PIXEL_TYPE) ptype = 8'h00;
                end
                2: frames = 0;
                3: ppf = 0;
                4: begin
                    len     = $urandom_range(0, need - 1);
                    n_bytes = (len == 0) ? 1 : len;
                end
                5: begin
                    if ($urandom_range(3) == 0) begin
                        // frame data just over the packet limit, length still fits
                        ppf     = 1;
                        frames  = 82 + $urandom_range(1);
                        len     = 255;
                        n_bytes = 255;
                    end else begin
                        frames  = frame_room + $urandom_range(1, 3);
                        len     = $urandom_range(HDR_BYTES, 40);
                        n_bytes = len;
                    end
                end
                6: n_bytes = $urandom_range(1, len - 1);
                default: begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0,
                                                            8'($urandom_range(255)));
                end
            endcase
        end
        send_packet(8'(len), ptype, mask, 8'(frames), 8'(ppf), n_bytes, 15);
        if ($urandom_range(9) < 3) repeat ($urandom_range(1, 3))
            send_read(5'($urandom_range(31)));
        if ($urandom_range(19) == 0) repeat ($urandom_range(1, 4)) send_noise();
    endtask

    task automatic write_config(input logic [7:0] group_data, input logic [7:0] strip_data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_DEVICE_GROUP;
        cfg_if.data  <= group_data;
        do @(posedge i_clk); while (!cfg_if.ready);
        mirror.set_register(REG_DEVICE_GROUP, group_data);
        cfg_if.index <= REG_STRIP_LENGTH;
        cfg_if.data  <= strip_data;
        do @(posedge i_clk); while (!cfg_if.ready);
        mirror.set_register(REG_STRIP_LENGTH, strip_data);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        pkt_if.valid <= 1'b0;
        while (mirror.due_readouts.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int send_idle [4];
        int recv_stall [4];
        send_idle  = '{0, 46, 0, 34};
        recv_stall = '{0, 0, 46, 34};

        i_rst_n              <= 1'b0;
        pkt_if.valid         <= 1'b0;
        pkt_if.command       <= CMD_BYTE;
        pkt_if.rx_byte       <= '0;
        pkt_if.first_byte    <= 1'b0;
        pkt_if.packet_length <= '0;
        pkt_if.read_index    <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty buffer, stray byte, one accepted frame, zero length
        send_read(5'd0);
        send_byte(8'hA5, 1'b0, 8'hFF);
        send_byte(PIXEL_TYPE, 1'b1, 8'd11);
        send_byte(8'h08, 1'b0, 8'd0);
        send_byte(8'h00, 1'b0, 8'd0);
        send_byte(8'd1, 1'b0, 8'd0);
        send_byte(8'd2, 1'b0, 8'd0);
        send_byte(8'hFF, 1'b0, 8'd0);
        send_byte(8'h00, 1'b0, 8'd0);
        send_byte(8'h80, 1'b0, 8'd0);
        send_byte(8'h00, 1'b0, 8'd0);
        send_byte(8'hFF, 1'b0, 8'd0);
        send_byte(8'h7F, 1'b0, 8'd0);
        send_read(5'd1);
        send_read(5'd31);
        send_byte(PIXEL_TYPE, 1'b1, 8'd0);
        drain();

        // zero strip length publishes an empty frame
        write_config(8'hF3, 8'hC0);
        send_packet(8'd8, PIXEL_TYPE, 16'h0008, 8'd1, 8'd1, 8, 0);
        send_read(5'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_config(8'hFF, 8'd32);
                1: write_config(8'h00, 8'h01);
                2: write_config(8'($urandom_range(255)), 8'hFF);
                default: write_config(8'($urandom_range(255)),
                                      {2'($urandom_range(3)), 6'($urandom_range(32))});
            endcase
            send_idle_pct  = send_idle[ph];
            recv_stall_pct <= recv_stall[ph];
            // long receiver hold-off while the sender keeps offering
            if (ph == 0) fork
                hold_off(150);
            join_none
            while (items_sent < 40 + 225 * (ph + 1)) random_packet();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.due_readouts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
